### src/gsnc_pkg.sv
// Package for the grid store with neighbor counting.
// Holds field widths, operation and register codes and the neighbor offset table.
// No dependencies.
package gsnc_pkg;

    // Parameter defaults
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_VALUE_BITS = 8;

    // Field widths
    localparam int OP_W       = 2;
    localparam int COORD_W    = 6;
    localparam int DATA_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    // Neighborhood modes
    localparam logic NB_MOORE       = 1'b0;
    localparam logic NB_VON_NEUMANN = 1'b1;

    // Reset values of the registers
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 7'd64;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 7'd64;

    typedef struct packed {
        logic signed [1:0] dc;
        logic signed [1:0] dr;
    } nb_offset_t;

    // Eight neighbors, visited one per step
    function automatic nb_offset_t nb_offset(input logic [2:0] step);
        nb_offset_t o;
        case (step)
            3'd0:    begin o.dc = -2'sd1; o.dr = -2'sd1; end
            3'd1:    begin o.dc =  2'sd0; o.dr = -2'sd1; end
            3'd2:    begin o.dc =  2'sd1; o.dr = -2'sd1; end
            3'd3:    begin o.dc = -2'sd1; o.dr =  2'sd0; end
            3'd4:    begin o.dc =  2'sd1; o.dr =  2'sd0; end
            3'd5:    begin o.dc = -2'sd1; o.dr =  2'sd1; end
            3'd6:    begin o.dc =  2'sd0; o.dr =  2'sd1; end
            default: begin o.dc =  2'sd1; o.dr =  2'sd1; end
        endcase
        return o;
    endfunction

endpackage

### src/gsnc_ram.sv
// Generic single-port RAM with registered read data.
// Read returns the old contents when read and write hit the same cycle.
// No dependencies.
module gsnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

### src/grid_store_neighbor_count.sv
// Top level of the grid store with neighbor counting.
// Depends on gsnc_pkg and gsnc_ram.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------
//  request   | start / busy           | operation, col, row, cell_value
//  result    | done (one-cycle pulse) | read_value, neighbor_count, index_error
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A write or a rejected request returns its result in the cycle after acceptance,
// a read after S_READ, a neighbor count after the S_COUNT steps and S_DRAIN: up to
// eight neighbor reads through the single memory port, one per cycle, plus a drain
// step. After reset a clearing pass over all MAX_COLS*MAX_ROWS cells (4096 by
// default) zeroes the store; busy stays high during it. Config writes are taken at
// any time. The result side cannot stall; each result shows for one cycle.
module grid_store_neighbor_count #(
    parameter int MAX_COLS   = gsnc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = gsnc_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = gsnc_pkg::DEF_VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [gsnc_pkg::OP_W-1:0]        operation,
    input  logic [gsnc_pkg::COORD_W-1:0]     col,
    input  logic [gsnc_pkg::COORD_W-1:0]     row,
    input  logic [gsnc_pkg::DATA_W-1:0]      cell_value,
    output logic                             done,
    output logic [gsnc_pkg::DATA_W-1:0]      read_value,
    output logic [gsnc_pkg::COUNT_W-1:0]     neighbor_count,
    output logic                             index_error,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gsnc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsnc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import gsnc_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_COUNT = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    // Control state
    logic [2:0]          state_reg,    state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [2:0]          step_reg,     step_next;
    logic                pend_reg,     pend_next;
    logic [COUNT_W-1:0]  acc_reg,      acc_next;
    logic                done_reg,     done_next;

    // Configuration
    logic [SIZE_W-1:0]     width_reg;
    logic [SIZE_W-1:0]     height_reg;
    logic [CFG_DATA_W-1:0] match_reg;
    logic                  mode_reg;

    // Payload
    logic [COORD_W-1:0]  col_reg,    col_next;
    logic [COORD_W-1:0]  row_reg,    row_next;
    logic [DATA_W-1:0]   rd_out_reg, rd_out_next;
    logic [COUNT_W-1:0]  cnt_out_reg, cnt_out_next;
    logic                err_out_reg, err_out_next;

    // Memory port
    logic                  ram_en;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic                    accept;
    logic                    in_ok;
    logic [SIZE_W-1:0]       used_cols;
    logic [SIZE_W-1:0]       used_rows;
    logic [VALUE_BITS+7:0]   wr_ext;
    logic [VALUE_BITS+7:0]   match_ext;
    logic [VALUE_BITS+7:0]   rd_ext;
    logic [VALUE_BITS-1:0]   match_val;
    nb_offset_t              nb;
    logic [7:0]              nb_col;
    logic [7:0]              nb_row;
    logic                    nb_use;
    logic                    hit;

    function automatic logic area_ok(input logic [7:0] c, input logic [7:0] r,
                                     input logic [SIZE_W-1:0] uc,
                                     input logic [SIZE_W-1:0] ur);
        return !c[7] && !r[7] && (c < {1'b0, uc}) && (r < {1'b0, ur});
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] c,
                                                    input logic [7:0] r);
        logic [ADDR_W+7:0] lin;
        lin = (ADDR_W+8)'(r) * (ADDR_W+8)'(MAX_COLS) + (ADDR_W+8)'(c);
        return lin[ADDR_W-1:0];
    endfunction

    // Clamp size registers to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            used_cols = SIZE_W'(1);
        else if (int'(width_reg) > MAX_COLS)
            used_cols = SIZE_W'(MAX_COLS);
        else
            used_cols = width_reg;

        if (height_reg == '0)
            used_rows = SIZE_W'(1);
        else if (int'(height_reg) > MAX_ROWS)
            used_rows = SIZE_W'(MAX_ROWS);
        else
            used_rows = height_reg;
    end

    assign wr_ext    = {{VALUE_BITS{1'b0}}, cell_value};
    assign match_ext = {{VALUE_BITS{1'b0}}, match_reg};
    assign match_val = match_ext[VALUE_BITS-1:0];
    assign rd_ext    = {8'b0, ram_rdata};

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign in_ok     = area_ok({2'b0, col}, {2'b0, row}, used_cols, used_rows);
    assign cfg_ready = 1'b1;

    assign nb     = nb_offset(step_reg);
    assign nb_col = {2'b0, col_reg} + {{6{nb.dc[1]}}, nb.dc};
    assign nb_row = {2'b0, row_reg} + {{6{nb.dr[1]}}, nb.dr};
    assign nb_use = area_ok(nb_col, nb_row, used_cols, used_rows)
                    && !(mode_reg == NB_VON_NEUMANN && nb.dc != 2'sd0 && nb.dr != 2'sd0);
    assign hit    = pend_reg && (ram_rdata == match_val);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        step_next     = step_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        done_next     = 1'b0;
        col_next      = col_reg;
        row_next      = row_reg;
        rd_out_next   = rd_out_reg;
        cnt_out_next  = cnt_out_reg;
        err_out_next  = err_out_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = cell_addr({2'b0, col}, {2'b0, row});
        ram_wdata     = wr_ext[VALUE_BITS-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                ram_en        = 1'b1;
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    col_next     = col;
                    row_next     = row;
                    rd_out_next  = '0;
                    cnt_out_next = '0;
                    err_out_next = 1'b0;
                    case (operation)
                        OP_WRITE:
                        begin
                            ram_en       = in_ok;
                            ram_we       = in_ok;
                            done_next    = 1'b1;
                            err_out_next = !in_ok;
                        end
                        OP_READ:
                        begin
                            if (in_ok)
                            begin
                                ram_en     = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                err_out_next = 1'b1;
                            end
                        end
                        OP_COUNT:
                        begin
                            if (in_ok)
                            begin
                                step_next  = '0;
                                pend_next  = 1'b0;
                                acc_next   = '0;
                                state_next = S_COUNT;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                err_out_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next   = 1'b1;
                rd_out_next = rd_ext[DATA_W-1:0];
                state_next  = S_IDLE;
            end
            S_COUNT:
            begin
                // Issue one neighbor read if the neighbor is in use, score the one issued last cycle
                ram_en    = nb_use;
                ram_addr  = cell_addr(nb_col, nb_row);
                pend_next = nb_use;
                acc_next  = acc_reg + {{(COUNT_W-1){1'b0}}, hit};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                done_next    = 1'b1;
                cnt_out_next = acc_reg + {{(COUNT_W-1){1'b0}}, hit};
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            step_reg     <= '0;
            pend_reg     <= 1'b0;
            acc_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            match_reg  <= '0;
            mode_reg   <= NB_MOORE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_MATCH:  match_reg  <= cfg_data;
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        rd_out_reg  <= rd_out_next;
        cnt_out_reg <= cnt_out_next;
        err_out_reg <= err_out_next;
    end

    gsnc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign done           = done_reg;
    assign read_value     = rd_out_reg;
    assign neighbor_count = cnt_out_reg;
    assign index_error    = err_out_reg;

    a_no_write_mid_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_COUNT || state_reg == S_DRAIN) |-> !ram_we)
        else $error("store written while a read or count is in progress");

    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_WRITE) |=> done)
        else $error("write request gave no result in the next cycle");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_READ && in_ok) |=> ##1 done)
        else $error("read request gave no result two cycles later");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> (read_value == '0 && neighbor_count == '0))
        else $error("error result carries nonzero data");

    a_vn_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg == NB_VON_NEUMANN) |-> (neighbor_count <= COUNT_W'(4)))
        else $error("four-neighbor count above four");

endmodule
